// ===== sv/dspf_pkg.sv =====
// shared types and constants of the diagonal seed pair finder
package dspf_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } dspf_state_t;

  // configuration register index, taken from the word address
  typedef enum logic {
    REG_MIN_SPACING = 1'b0,
    REG_MAX_SPACING = 1'b1
  } dspf_reg_t;

  localparam int MIN_SPACING_RST = 5;
  localparam int MAX_SPACING_RST = 64;

endpackage

// ===== sv/dspf_store.sv =====
// seed store memory: one write port, one registered read port
module dspf_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/dspf_cmp.sv =====
// shared compare unit: checks one stored seed against the current seed
module dspf_cmp #(
  parameter int PW = 12
) (
  input  logic [PW-1:0] cur_q,
  input  logic [PW-1:0] cur_r,
  input  logic [PW-1:0] st_q,
  input  logic [PW-1:0] st_r,
  input  logic [PW-1:0] min_sp,
  input  logic [PW-1:0] max_sp,
  output logic          match,
  output logic [PW-1:0] q_lo,
  output logic [PW-1:0] r_lo,
  output logic [PW-1:0] spacing
);

  logic          q_ge;
  logic [PW:0]   sum_a;
  logic [PW:0]   sum_b;

  // same diagonal: st_q - st_r == cur_q - cur_r, rearranged to avoid signs
  assign sum_a = {1'b0, st_q} + {1'b0, cur_r};
  assign sum_b = {1'b0, cur_q} + {1'b0, st_r};

  assign q_ge    = (cur_q >= st_q);
  assign spacing = q_ge ? (cur_q - st_q) : (st_q - cur_q);
  assign q_lo    = q_ge ? st_q : cur_q;
  assign r_lo    = (cur_r < st_r) ? cur_r : st_r;

  assign match = (sum_a == sum_b) && (spacing >= min_sp) && (spacing <= max_sp);

endmodule

// ===== sv/diagonal_seed_pair_finder_core.sv =====
// diagonal seed pair finder: sequencer, config registers and result register
// a new seed is taken only in the idle state, once the scan for the previous seed is done;
// the scan reads one stored seed per cycle, unless a blocked result holds it; with an
// empty store there is no scan and the seed goes straight into the store
// a pair waits in a holding register until the next hit or the end of the scan; a blocked
// result stalls the scan. reset empties the store, clears overflow, loads spacing defaults
module diagonal_seed_pair_finder_core
  import dspf_pkg::*;
#(
  parameter int MAX_SEEDS = 64,
  parameter int POS_WIDTH = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_start_new_set,
  input  logic [POS_WIDTH-1:0] in_seed_query_pos,
  input  logic [POS_WIDTH-1:0] in_seed_ref_pos,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [POS_WIDTH-1:0] out_diag_query_start,
  output logic [POS_WIDTH-1:0] out_diag_ref_start,
  output logic [POS_WIDTH-1:0] out_diag_length,
  output logic                 out_last_of_run,
  output logic                 out_store_overflowed,

  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int AW          = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CW          = $clog2(MAX_SEEDS + 1);
  localparam int DW          = 2 * POS_WIDTH;
  localparam int MAX_RESULTS = MAX_SEEDS - 1;

  // configuration
  logic [POS_WIDTH-1:0] min_sp_r;
  logic [POS_WIDTH-1:0] max_sp_r;
  logic                 cfg_wr;
  dspf_reg_t            cfg_sel;

  // sequencer
  dspf_state_t          state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        hits_r, hits_nxt;
  logic                 rd_v_r, rd_v_nxt;
  logic [POS_WIDTH-1:0] cur_q_r;
  logic [POS_WIDTH-1:0] cur_r_r;

  // pending pair, held until the next hit or the end of the scan
  logic                 pend_v_r, pend_v_nxt;
  logic [POS_WIDTH-1:0] pend_q_r, pend_r_r, pend_len_r;
  logic                 pend_load;

  // result register
  logic                 out_v_r, out_v_nxt;
  logic [POS_WIDTH-1:0] out_q_r, out_r_r, out_len_r;
  logic                 out_last_r, out_ovf_r;
  logic                 out_load, out_last_nxt, out_free;

  logic                 in_acc;
  logic [CW-1:0]        cnt_eff;
  logic                 issue, adv, hit, scan_done, fin_go, st_wr;
  logic [DW-1:0]        rd_data;
  logic                 cmp_match;
  logic [POS_WIDTH-1:0] cmp_q, cmp_r, cmp_len;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_sel    = dspf_reg_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sp_r <= POS_WIDTH'(MIN_SPACING_RST);
      max_sp_r <= POS_WIDTH'(MAX_SPACING_RST);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_MIN_SPACING: min_sp_r <= cfg_pwdata[POS_WIDTH-1:0];
        REG_MAX_SPACING: max_sp_r <= cfg_pwdata[POS_WIDTH-1:0];
        default:         min_sp_r <= min_sp_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_MIN_SPACING: cfg_prdata = 32'(min_sp_r);
      REG_MAX_SPACING: cfg_prdata = 32'(max_sp_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // store and compare unit
  dspf_store #(
    .DEPTH (MAX_SEEDS),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data ({cur_q_r, cur_r_r}),
    .rd_en   (issue),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  dspf_cmp #(
    .PW (POS_WIDTH)
  ) u_cmp (
    .cur_q   (cur_q_r),
    .cur_r   (cur_r_r),
    .st_q    (rd_data[DW-1:POS_WIDTH]),
    .st_r    (rd_data[POS_WIDTH-1:0]),
    .min_sp  (min_sp_r),
    .max_sp  (max_sp_r),
    .match   (cmp_match),
    .q_lo    (cmp_q),
    .r_lo    (cmp_r),
    .spacing (cmp_len)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cnt_eff  = in_start_new_set ? '0 : cnt_r;
  assign out_free = !out_v_r || !out_stall;

  // matches past the per-seed result limit are dropped
  assign hit       = rd_v_r && cmp_match && (hits_r < CW'(MAX_RESULTS));
  assign adv       = !(hit && pend_v_r && !out_free);
  assign issue     = (state_r == ST_SCAN) && (idx_r < cnt_r) && adv;
  assign scan_done = (state_r == ST_SCAN) && (idx_r >= cnt_r) && !rd_v_r;
  assign fin_go    = (state_r == ST_FIN) && (!pend_v_r || out_free);
  assign st_wr     = fin_go && (cnt_r < CW'(MAX_SEEDS));
  assign pend_load = adv && hit;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    idx_nxt      = idx_r;
    hits_nxt     = hits_r;
    rd_v_nxt     = rd_v_r;
    pend_v_nxt   = pend_v_r;
    out_load     = 1'b0;
    out_last_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt   = cnt_eff;
          ovf_nxt   = (in_start_new_set ? 1'b0 : ovf_r) || (cnt_eff == CW'(MAX_SEEDS));
          idx_nxt   = '0;
          hits_nxt  = '0;
          rd_v_nxt  = 1'b0;
          state_nxt = (cnt_eff == '0) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv) begin
          rd_v_nxt = issue;
          if (issue) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        if (pend_load) begin
          hits_nxt   = hits_r + 1'b1;
          pend_v_nxt = 1'b1;
          out_load   = pend_v_r;
        end
        if (scan_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_load     = pend_v_r;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
          if (cnt_r < CW'(MAX_SEEDS)) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_v_nxt = out_load ? 1'b1 : (out_v_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      idx_r    <= '0;
      hits_r   <= '0;
      rd_v_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      idx_r    <= idx_nxt;
      hits_r   <= hits_nxt;
      rd_v_r   <= rd_v_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_q_r <= in_seed_query_pos;
      cur_r_r <= in_seed_ref_pos;
    end
    if (pend_load) begin
      pend_q_r   <= cmp_q;
      pend_r_r   <= cmp_r;
      pend_len_r <= cmp_len;
    end
    if (out_load) begin
      out_q_r    <= pend_q_r;
      out_r_r    <= pend_r_r;
      out_len_r  <= pend_len_r;
      out_last_r <= out_last_nxt;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid            = out_v_r;
  assign out_diag_query_start = out_q_r;
  assign out_diag_ref_start   = out_r_r;
  assign out_diag_length      = out_len_r;
  assign out_last_of_run      = out_last_r;
  assign out_store_overflowed = out_ovf_r;

endmodule

// ===== test/diagonal_seed_pair_finder_core_test.sv =====
// self-checking testbench for the diagonal seed pair finder core
`timescale 1ns / 100ps

module diagonal_seed_pair_finder_core_test
  import dspf_pkg::*;
();

  localparam int MAX_SEEDS = 64;
  localparam int MAX_PAIRS = 63;
  localparam int SETTLE_CYCLES = MAX_SEEDS + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [11:0] qs;
    logic [11:0] rs;
    logic [11:0] len;
    logic        last;
    logic        ovf;
  } pair_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } check_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  typedef struct packed {
    logic        is_write;
    dspf_reg_t   reg_idx;
    logic [11:0] reg_val;
    logic        start;
    logic [11:0] qpos;
    logic [11:0] rpos;
    check_t      chk;
    pair_t       want;
  } plan_row_t;

  localparam pair_t NO_PAIR = '0;

  // directed walk: reset defaults first, then the extremes, then crossed limits
  localparam plan_row_t DIRECTED [24] = '{
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b1, 12'd100, 12'd50, CHK_NONE, NO_PAIR},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b0, 12'd110, 12'd60, CHK_ONE,
      '{12'd100, 12'd50, 12'd10, 1'b1, 1'b0}},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b0, 12'd105, 12'd60, CHK_NONE, NO_PAIR},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b0, 12'd102, 12'd52, CHK_ONE,
      '{12'd102, 12'd52, 12'd8, 1'b1, 1'b0}},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b0, 12'd174, 12'd124, CHK_ONE,
      '{12'd110, 12'd60, 12'd64, 1'b1, 1'b0}},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b0, 12'd169, 12'd119, CHK_MODEL, NO_PAIR},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b1, 12'd4095, 12'd4095, CHK_NONE, NO_PAIR},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b0, 12'd0, 12'd0, CHK_NONE, NO_PAIR},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b0, 12'd4095, 12'd0, CHK_NONE, NO_PAIR},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b0, 12'd0, 12'd4095, CHK_NONE, NO_PAIR},
    '{1'b1, REG_MIN_SPACING, 12'd0, 1'b0, 12'd0, 12'd0, CHK_NONE, NO_PAIR},
    '{1'b1, REG_MAX_SPACING, 12'd4095, 1'b0, 12'd0, 12'd0, CHK_NONE, NO_PAIR},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b1, 12'd0, 12'd0, CHK_NONE, NO_PAIR},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b0, 12'd4095, 12'd4095, CHK_ONE,
      '{12'd0, 12'd0, 12'd4095, 1'b1, 1'b0}},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b0, 12'd0, 12'd0, CHK_MODEL, NO_PAIR},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b0, 12'd4095, 12'd0, CHK_NONE, NO_PAIR},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b0, 12'd2048, 12'd2048, CHK_MODEL, NO_PAIR},
    '{1'b1, REG_MIN_SPACING, 12'd100, 1'b0, 12'd0, 12'd0, CHK_NONE, NO_PAIR},
    '{1'b1, REG_MAX_SPACING, 12'd10, 1'b0, 12'd0, 12'd0, CHK_NONE, NO_PAIR},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b1, 12'd50, 12'd20, CHK_NONE, NO_PAIR},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b0, 12'd80, 12'd50, CHK_NONE, NO_PAIR},
    '{1'b0, REG_MIN_SPACING, 12'd0, 1'b0, 12'd200, 12'd170, CHK_NONE, NO_PAIR},
    '{1'b1, REG_MIN_SPACING, 12'd5, 1'b0, 12'd0, 12'd0, CHK_NONE, NO_PAIR},
    '{1'b1, REG_MAX_SPACING, 12'd64, 1'b0, 12'd0, 12'd0, CHK_NONE, NO_PAIR}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_start_new_set = 1'b0;
  logic [11:0] in_seed_query_pos = '0;
  logic [11:0] in_seed_ref_pos = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_diag_query_start;
  logic [11:0] out_diag_ref_start;
  logic [11:0] out_diag_length;
  logic        out_last_of_run;
  logic        out_store_overflowed;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // seed store as the block should hold it
  logic [11:0] seen_q [MAX_SEEDS];
  logic [11:0] seen_r [MAX_SEEDS];
  int          seen_cnt = 0;
  logic        set_overflow = 1'b0;
  logic [11:0] min_gap = 12'(MIN_SPACING_RST);
  logic [11:0] max_gap = 12'(MAX_SPACING_RST);

  pair_t       found [$];
  pair_t       pending_pairs [$];
  int          errors = 0;
  int          cycle_cnt = 0;
  int          burst_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_started = 1'b0;
  int          hold_left = 0;
  int          seg_left = 0;
  stall_mode_t seg_mode = STALL_NONE;

  diagonal_seed_pair_finder_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_start_new_set     (in_start_new_set),
    .in_seed_query_pos    (in_seed_query_pos),
    .in_seed_ref_pos      (in_seed_ref_pos),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_diag_query_start (out_diag_query_start),
    .out_diag_ref_start   (out_diag_ref_start),
    .out_diag_length      (out_diag_length),
    .out_last_of_run      (out_last_of_run),
    .out_store_overflowed (out_store_overflowed),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("diagonal_seed_pair_finder_core: mismatch");
      $finish;
    end
  end

  // pairs caused by one new seed, then the seed goes into the store
  function automatic void find_pairs(input logic start, input logic [11:0] q,
                                     input logic [11:0] r);
    int   sp;
    pair_t p;
    found.delete();
    if (start) begin
      seen_cnt = 0;
      set_overflow = 1'b0;
    end
    if (seen_cnt >= MAX_SEEDS) set_overflow = 1'b1;
    for (int i = 0; i < seen_cnt && found.size() < MAX_PAIRS; i++) begin
      sp = (q > seen_q[i]) ? int'(q) - int'(seen_q[i]) : int'(seen_q[i]) - int'(q);
      if (sp >= int'(min_gap) && sp <= int'(max_gap) &&
          int'(q) - int'(r) == int'(seen_q[i]) - int'(seen_r[i])) begin
        p.qs = (q < seen_q[i]) ? q : seen_q[i];
        p.rs = (r < seen_r[i]) ? r : seen_r[i];
        p.len = 12'(sp);
        p.last = 1'b0;
        p.ovf = 1'b0;
        found.insert(found.size(), p);
      end
    end
    foreach (found[k]) found[k].ovf = set_overflow;
    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    if (seen_cnt < MAX_SEEDS) begin
      seen_q[seen_cnt] = q;
      seen_r[seen_cnt] = r;
      seen_cnt++;
    end
  endfunction

  function automatic void check_field(input string name, input logic [11:0] want,
                                      input logic [11:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // results are compared at the falling edge before the rising edge that takes them
  always @(negedge clk) begin
    pair_t got;
    pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_diag_query_start, out_diag_ref_start, out_diag_length,
              out_last_of_run, out_store_overflowed};
      if (pending_pairs.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t ns: unexpected transaction, expected none, actual %h", $time, got);
      end else begin
        want = pending_pairs.pop_front();
        check_field("diag_query_start", want.qs, got.qs);
        check_field("diag_ref_start", want.rs, got.rs);
        check_field("diag_length", want.len, got.len);
        check_field("last_of_run", 12'(want.last), 12'(got.last));
        check_field("store_overflowed", 12'(want.ovf), 12'(got.ovf));
      end
    end
  end

  // receiver: segments of differing stall density, plus one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 40);
        seg_mode = stall_mode_t'($urandom_range(0, 3));
      end
      seg_left--;
      case (seg_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 4) < 3);
        default: out_stall <= !out_stall;
      endcase
    end
  end

  task automatic offer_seed(input logic start, input logic [11:0] q, input logic [11:0] r,
                            input check_t chk, input pair_t want);
    int   gap;
    logic taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_start_new_set <= start;
    in_seed_query_pos <= q;
    in_seed_ref_pos <= r;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    find_pairs(start, q, r);
    case (chk)
      CHK_MODEL: foreach (found[k]) pending_pairs.insert(pending_pairs.size(), found[k]);
      CHK_ONE: pending_pairs.insert(pending_pairs.size(), want);
      default: ;
    endcase
  endtask

  // drain every pending pair, then allow for a scan that yields nothing
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input dspf_reg_t idx, input logic [11:0] val);
    logic done;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {20'($urandom), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      done = cfg_pready;
      @(posedge clk);
    end
    if (idx == REG_MIN_SPACING) min_gap = val;
    else max_gap = val;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // one seed set on a single diagonal, query positions spread over a window, noise_pct percent of seeds at random
  task automatic feed_set(input int len, input int window, input int noise_pct);
    int          d;
    int          lo;
    int          hi;
    int          q0;
    int          q;
    logic [11:0] qn;
    logic [11:0] rn;
    d = int'($urandom_range(0, 600)) - 300;
    lo = (d > 0) ? d : 0;
    hi = (d < 0) ? 4095 + d : 4095;
    if (window > hi - lo) window = hi - lo;
    q0 = $urandom_range(lo, hi - window);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        qn = 12'($urandom);
        rn = 12'($urandom);
      end else begin
        q = q0 + int'($urandom_range(0, window));
        qn = 12'(q);
        rn = 12'(q - d);
      end
      offer_seed(k == 0, qn, rn, CHK_MODEL, NO_PAIR);
    end
  endtask

  initial begin
    int          sent;
    int          n;
    logic [11:0] v;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_write) begin
        settle();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
      end else begin
        offer_seed(DIRECTED[i].start, DIRECTED[i].qpos, DIRECTED[i].rpos,
                   DIRECTED[i].chk, DIRECTED[i].want);
      end
    end

    // full store on one diagonal: overflow and the per-seed result cap
    settle();
    write_reg(REG_MIN_SPACING, 12'd0);
    write_reg(REG_MAX_SPACING, 12'd4095);
    hold_req = 1'b1;
    feed_set(MAX_SEEDS + 3, 4095, 0);

    settle();
    v = 12'($urandom_range(0, 20));
    write_reg(REG_MIN_SPACING, v);
    write_reg(REG_MAX_SPACING, 12'($urandom_range(int'(v), 300)));
    sent = 0;
    while (sent < 16) begin
      n = $urandom_range(2, 8);
      feed_set(n, 300, 15);
      sent += n;
    end

    // top of both limits: only the corner-to-corner spacing pairs
    settle();
    write_reg(REG_MIN_SPACING, 12'd4095);
    write_reg(REG_MAX_SPACING, 12'd4095);
    for (int k = 0; k < 6; k++) begin
      v = ($urandom_range(0, 1) == 1) ? 12'd4095 : 12'd0;
      offer_seed(k == 0, v, v, CHK_MODEL, NO_PAIR);
    end

    settle();
    write_reg(REG_MIN_SPACING, 12'($urandom));
    write_reg(REG_MAX_SPACING, 12'($urandom));
    feed_set(3, 4095, 0);
    feed_set(3, 4095, 10);

    settle();
    write_reg(REG_MIN_SPACING, 12'(MIN_SPACING_RST));
    write_reg(REG_MAX_SPACING, 12'(MAX_SPACING_RST));
    sent = 0;
    while (sent < 12) begin
      n = $urandom_range(3, 6);
      feed_set(n, 100, 10);
      sent += n;
    end

    settle();
    if (errors == 0) begin
      $display("diagonal_seed_pair_finder_core: match");
    end else begin
      $display("diagonal_seed_pair_finder_core: mismatch");
    end
    $finish;
  end

endmodule
